[rtl/core/hts_pkg.sv]
// shared types, widths and constants of the hybrid torque split unit
`default_nettype none

package hts_pkg;

    // field widths
    localparam int PEDAL_W = 13;
    localparam int SOC_W   = 13;
    localparam int SPD_W   = 12;
    localparam int RPM_W   = 15;
    localparam int REQ_W   = 15;
    localparam int SC_W    = 6;
    localparam int MOT_W   = 14;
    localparam int TGT_W   = 13;
    localparam int MODE_W  = 3;

    // default depth of the queue between front and back
    localparam int HTS_QUEUE_DEPTH = 4;

    typedef enum logic [MODE_W-1:0] {
        MODE_IDLE   = 3'd0,
        MODE_REGEN  = 3'd1,
        MODE_CHARGE = 3'd2,
        MODE_LIGHT  = 3'd3,
        MODE_NORMAL = 3'd4,
        MODE_HIGH   = 3'd5
    } drive_mode_t;

    // one classified item handed from front to back
    typedef struct packed {
        logic signed [REQ_W-1:0] req;
        drive_mode_t             mode;
        logic [SC_W-1:0]         sc;
        logic signed [RPM_W-1:0] rpm;
    } hts_item_t;

    // torque limits in 1/16 Nm
    localparam logic signed [15:0] MOT_REGEN_T16 = -16'sd3200;
    localparam logic signed [15:0] MOT_MAX_T16   = 16'sd4320;

endpackage

`default_nettype wire

[rtl/core/hybrid_torque_split_unit.sv]
// top level of the hybrid torque split unit
// path: an accepted input beat passes the front register, the queue and the seven back stages to the output register
// throughput: one beat per cycle while results are read; the front stage, the queue and the seven-stage back pipe
// move unless stalled, the back pipe holds as a whole while a result beat waits
// reset: rst_n asynchronous active low clears all valid flags, queue pointers and count
`default_nettype none

module hybrid_torque_split_unit
    import hts_pkg::*;
#(
    parameter int QUEUE_DEPTH = HTS_QUEUE_DEPTH
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // pedal_position[12:0], battery_charge[25:13], road_speed[37:26],
    // motor_speed[52:38], zero[55:53]
    input  wire logic [55:0] s_tdata,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // motor_torque_cmd[13:0], engine_speed_target[26:14], drive_mode[29:27], zero[31:30]
    output logic [31:0]      m_tdata
);

    // front to queue
    logic      fq_valid;
    logic      fq_ready;
    hts_item_t fq_item;
    // queue to back
    logic      qb_valid;
    logic      qb_ready;
    hts_item_t qb_item;

    logic signed [MOT_W-1:0] motor_torque_cmd;
    logic [TGT_W-1:0]        engine_speed_target;
    drive_mode_t             drive_mode;

    // front: torque request from pedal and speed band, mode and split factor
    hts_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (s_tvalid),
        .in_ready       (s_tready),
        .pedal_position (s_tdata[12:0]),
        .battery_charge (s_tdata[25:13]),
        .road_speed     (s_tdata[37:26]),
        .motor_speed    (s_tdata[52:38]),
        .out_valid      (fq_valid),
        .out_ready      (fq_ready),
        .out_item       (fq_item)
    );

    // decouples the two halves so each can stall on its own
    hts_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fq_valid),
        .in_ready  (fq_ready),
        .in_item   (fq_item),
        .out_valid (qb_valid),
        .out_ready (qb_ready),
        .out_item  (qb_item)
    );

    // back: split, clamp, engine target, power derate; last stage is the output register
    hts_back u_back (
        .clk                 (clk),
        .rst_n               (rst_n),
        .in_valid            (qb_valid),
        .in_ready            (qb_ready),
        .in_item             (qb_item),
        .out_valid           (m_tvalid),
        .out_ready           (m_tready),
        .motor_torque_cmd    (motor_torque_cmd),
        .engine_speed_target (engine_speed_target),
        .drive_mode          (drive_mode)
    );

    // result beat packing, lowest field first
    assign m_tdata = {2'b00, drive_mode, engine_speed_target, motor_torque_cmd};

endmodule

`default_nettype wire

[rtl/core/hts_front.sv]
// front end: torque request, drive mode and split factor per beat
`default_nettype none

module hts_front
    import hts_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [PEDAL_W-1:0]   pedal_position,
    input  wire logic [SOC_W-1:0]     battery_charge,
    input  wire logic [SPD_W-1:0]     road_speed,
    input  wire logic [RPM_W-1:0]     motor_speed,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output hts_item_t                 out_item
);

    localparam logic signed [15:0] IDLE_BAND_T16  = 16'sd80;
    localparam logic signed [15:0] LIGHT_MAX_T16  = 16'sd1627;
    localparam logic signed [15:0] NORMAL_LIM_T16 = 16'sd4068;

    logic                    valid_reg;
    logic signed [22:0]      prod_reg;
    logic signed [22:0]      prod_next;
    logic [SOC_W-1:0]        soc_reg;
    logic [SPD_W-1:0]        spd_reg;
    logic signed [RPM_W-1:0] rpm_reg;
    logic                    adv;
    logic [13:0]             eq_q12;
    logic signed [13:0]      diff;
    logic signed [23:0]      rsum;
    logic signed [REQ_W-1:0] req;
    logic [2:0]              spd_tenths;
    logic [3:0]              soc_tenths;
    drive_mode_t             mode;

    function automatic logic battery_charge_low(input logic [SOC_W-1:0] soc);
        return soc < 13'd1024;
    endfunction

    assign adv      = !valid_reg || out_ready;
    assign in_ready = adv;

    // equilibrium pedal by speed band
    always_comb
    begin
        if (road_speed < 12'd80)
            eq_q12 = 14'd614;
        else if (road_speed < 12'd320)
            eq_q12 = 14'd819;
        else
            eq_q12 = 14'd1024;
        diff      = $signed({1'b0, pedal_position}) - $signed(eq_q12);
        prod_next = diff * 10'sd339;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (adv)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (adv && in_valid)
        begin
            prod_reg <= prod_next;
            soc_reg  <= battery_charge;
            spd_reg  <= road_speed;
            rpm_reg  <= $signed(motor_speed);
        end
    end

    // round to nearest, ties upward, divide by 256
    always_comb
    begin
        rsum = prod_reg + 24'sd128;
        req  = $signed(rsum[22:8]);
    end

    always_comb
    begin
        if (battery_charge_low(soc_reg))
            mode = MODE_CHARGE;
        else if (req < MOT_REGEN_T16)
            mode = MODE_REGEN;
        else if (req > -IDLE_BAND_T16 && req < IDLE_BAND_T16)
            mode = MODE_IDLE;
        else if (req <= LIGHT_MAX_T16)
            mode = MODE_LIGHT;
        else if (req < NORMAL_LIM_T16)
            mode = MODE_NORMAL;
        else
            mode = MODE_HIGH;
    end

    // speed factor in tenths
    always_comb
    begin
        if (spd_reg < 12'd160)
            spd_tenths = 3'd5;
        else if (spd_reg < 12'd400)
            spd_tenths = 3'd4;
        else if (spd_reg < 12'd640)
            spd_tenths = 3'd3;
        else
            spd_tenths = 3'd2;
    end

    // charge factor in tenths
    always_comb
    begin
        if (soc_reg > 13'd2867)
            soc_tenths = 4'd12;
        else if (soc_reg > 13'd2252)
            soc_tenths = 4'd10;
        else if (soc_reg > 13'd1843)
            soc_tenths = 4'd7;
        else if (soc_reg > 13'd1433)
            soc_tenths = 4'd4;
        else if (soc_reg > 13'd1024)
            soc_tenths = 4'd1;
        else
            soc_tenths = 4'd0;
    end

    assign out_valid     = valid_reg;
    assign out_item.req  = req;
    assign out_item.mode = mode;
    assign out_item.sc   = SC_W'(spd_tenths) * SC_W'(soc_tenths);
    assign out_item.rpm  = rpm_reg;

endmodule

`default_nettype wire

[rtl/core/hts_queue.sv]
// small fifo between front and back
`default_nettype none

module hts_queue
    import hts_pkg::*;
#(
    parameter int DEPTH = HTS_QUEUE_DEPTH
)
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    input  wire hts_item_t in_item,
    output logic           out_valid,
    input  wire logic      out_ready,
    output hts_item_t      out_item
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hts_item_t          mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push;
    logic               pop;

    assign in_ready  = count_reg != CNT_W'(DEPTH);
    assign out_valid = count_reg != '0;
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign out_item  = mem_reg[rd_ptr_reg];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            if (pop)
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            if (push && !pop)
                count_reg <= count_reg + 1'b1;
            else if (pop && !push)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wr_ptr_reg] <= in_item;
    end

endmodule

`default_nettype wire

[rtl/core/hts_back.sv]
// back end: torque split, clamp, engine target and power derate pipeline
`default_nettype none

module hts_back
    import hts_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire hts_item_t          in_item,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic signed [MOT_W-1:0] motor_torque_cmd,
    output logic [TGT_W-1:0]        engine_speed_target,
    output drive_mode_t             drive_mode
);

    localparam int STAGES = 7;

    // ceil(2^27/100) and ceil(2^20/10), exact over the ranges used here
    localparam logic [20:0] RECIP100 = 21'd1342178;
    localparam logic [16:0] RECIP10  = 17'd104858;

    localparam logic signed [28:0] DISCH_PROD_MAX = 29'sd9167324;
    localparam logic signed [28:0] CHG_PROD_MIN   = -29'sd6111549;

    logic [STAGES-1:0]       vld_reg;
    logic                    adv;

    // stage 1
    logic signed [21:0]      sc_prod;
    logic [19:0]             u1_reg;
    logic signed [REQ_W-1:0] req1_reg;
    drive_mode_t             mode1_reg;
    logic signed [RPM_W-1:0] rpm1_reg;
    // stage 2
    logic [40:0]             p100;
    logic [13:0]             q2_reg;
    logic signed [REQ_W-1:0] req2_reg;
    drive_mode_t             mode2_reg;
    logic signed [RPM_W-1:0] rpm2_reg;
    // stage 3
    logic signed [14:0]      share;
    logic signed [14:0]      share_clamped;
    logic signed [MOT_W-1:0] mot3_next;
    logic signed [15:0]      eng;
    logic [TGT_W-1:0]        tgt3_next;
    logic signed [MOT_W-1:0] mot3_reg;
    logic [TGT_W-1:0]        tgt3_reg;
    drive_mode_t             mode3_reg;
    logic signed [RPM_W-1:0] rpm3_reg;
    // stage 4
    logic signed [28:0]      pw4_reg;
    logic signed [MOT_W-1:0] mot4_reg;
    logic [TGT_W-1:0]        tgt4_reg;
    drive_mode_t             mode4_reg;
    // stage 5
    logic                    hi;
    logic                    lo;
    logic signed [17:0]      num;
    logic [16:0]             u5_reg;
    logic                    der5_reg;
    logic signed [MOT_W-1:0] mot5_reg;
    logic [TGT_W-1:0]        tgt5_reg;
    drive_mode_t             mode5_reg;
    // stage 6
    logic [33:0]             p10;
    logic [12:0]             q6_reg;
    logic                    der6_reg;
    logic signed [MOT_W-1:0] mot6_reg;
    logic [TGT_W-1:0]        tgt6_reg;
    drive_mode_t             mode6_reg;
    // stage 7, output
    logic signed [MOT_W-1:0] mot7_reg;
    logic [TGT_W-1:0]        tgt7_reg;
    drive_mode_t             mode7_reg;

    // whole pipe moves unless a result sits unread
    assign adv       = !vld_reg[STAGES-1] || out_ready;
    assign in_ready  = adv;
    assign out_valid = vld_reg[STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[STAGES-2:0], in_valid};
    end

    // request times speed and charge tenths, offset so the divide sees a positive value
    assign sc_prod = in_item.req * $signed({1'b0, in_item.sc});

    assign p100 = 41'(u1_reg) * 41'(RECIP100);

    // motor share, clamp and mode override
    always_comb
    begin
        share = $signed({1'b0, q2_reg}) - 15'sd1000;
        if (share > MOT_MAX_T16)
            share_clamped = 15'(MOT_MAX_T16);
        else if (share < MOT_REGEN_T16)
            share_clamped = 15'(MOT_REGEN_T16);
        else
            share_clamped = share;
        case (mode2_reg)
            MODE_REGEN:  mot3_next = 14'(MOT_REGEN_T16);
            MODE_CHARGE: mot3_next = '0;
            default:     mot3_next = 14'(share_clamped);
        endcase
    end

    // engine speed from engine torque share of 339 Nm
    always_comb
    begin
        eng = 16'(req2_reg) - 16'(mot3_next);
        if (eng < 16'sd272)
            tgt3_next = 13'd800;
        else if (eng < 16'sd814)
            tgt3_next = 13'd1800;
        else if (eng < 16'sd1899)
            tgt3_next = 13'd2200;
        else if (eng < 16'sd3526)
            tgt3_next = 13'd2800;
        else if (eng < 16'sd4611)
            tgt3_next = 13'd3600;
        else
            tgt3_next = 13'd5200;
        case (mode2_reg)
            MODE_REGEN:  tgt3_next = 13'd900;
            MODE_CHARGE: tgt3_next = 13'd2500;
            default:     tgt3_next = tgt3_next;
        endcase
    end

    // power limit check and derate numerator (scale 0.8 or 0.7, over ten)
    always_comb
    begin
        hi = pw4_reg > DISCH_PROD_MAX;
        lo = pw4_reg < CHG_PROD_MIN;
        if (hi)
            num = 18'(mot4_reg) * 18'sd8 + 18'sd5;
        else
            num = 18'(mot4_reg) * 18'sd7 + 18'sd5;
    end

    assign p10 = 34'(u5_reg) * 34'(RECIP10);

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            u1_reg    <= 20'(sc_prod + 22'sd100050);
            req1_reg  <= in_item.req;
            mode1_reg <= in_item.mode;
            rpm1_reg  <= in_item.rpm;

            q2_reg    <= p100[40:27];
            req2_reg  <= req1_reg;
            mode2_reg <= mode1_reg;
            rpm2_reg  <= rpm1_reg;

            mot3_reg  <= mot3_next;
            tgt3_reg  <= tgt3_next;
            mode3_reg <= mode2_reg;
            rpm3_reg  <= rpm2_reg;

            pw4_reg   <= mot3_reg * rpm3_reg;
            mot4_reg  <= mot3_reg;
            tgt4_reg  <= tgt3_reg;
            mode4_reg <= mode3_reg;

            u5_reg    <= 17'(num + 18'sd40000);
            der5_reg  <= hi || lo;
            mot5_reg  <= mot4_reg;
            tgt5_reg  <= tgt4_reg;
            mode5_reg <= mode4_reg;

            q6_reg    <= p10[32:20];
            der6_reg  <= der5_reg;
            mot6_reg  <= mot5_reg;
            tgt6_reg  <= tgt5_reg;
            mode6_reg <= mode5_reg;

            mot7_reg  <= der6_reg ? ($signed({1'b0, q6_reg}) - 14'sd4000) : mot6_reg;
            tgt7_reg  <= tgt6_reg;
            mode7_reg <= mode6_reg;
        end
    end

    assign motor_torque_cmd    = mot7_reg;
    assign engine_speed_target = tgt7_reg;
    assign drive_mode          = mode7_reg;

endmodule

`default_nettype wire
